// File: hw/rtl/mlfs_pkg.sv
// ----------------------------------------------------------------------------
// mlfs_pkg
// Shared types and constants of the multi-LED flash sequencer: request and
// result formats, per-LED command and status records, divider constants.
// ----------------------------------------------------------------------------
package mlfs_pkg;

  // Number of LED sequencers and the tick period in milliseconds.
  localparam int NUM_LEDS = 4;
  localparam int TICK_MS  = 10;

  // Field widths fixed by the interface.
  localparam int MASK_W = 4;
  localparam int TIME_W = 16;
  localparam int CNT_W  = 8;

  // Request command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Divide by TICK_MS: multiply by a floored reciprocal, then one correction.
  localparam int DIV_SH   = TIME_W;
  localparam int RECIP_W  = TIME_W + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((64'd1 << DIV_SH) / TICK_MS);
  localparam logic [TIME_W-1:0]  TICK_VAL  = TIME_W'(TICK_MS);

  // Mask of the ready bits that exist on the result port.
  localparam int VIS_LEDS = (NUM_LEDS < MASK_W) ? NUM_LEDS : MASK_W;
  localparam logic [MASK_W-1:0] READY_ALL = MASK_W'((64'd1 << VIS_LEDS) - 64'd1);

  typedef struct packed {
    logic              cmd;
    logic [MASK_W-1:0] led_mask;
    logic [TIME_W-1:0] on_time_ms;
    logic [TIME_W-1:0] off_time_ms;
    logic [CNT_W-1:0]  flash_count;
  } in_req_t;

  typedef struct packed {
    logic [MASK_W-1:0] pin_levels;
    logic [MASK_W-1:0] ready_mask;
    logic              all_idle;
  } out_res_t;

  // Command broadcast to one LED sequencer.
  typedef struct packed {
    logic              start;
    logic              tick;
    logic [TIME_W-1:0] on_ticks;
    logic [TIME_W-1:0] off_ticks;
    logic [CNT_W-1:0]  cycles;
  } lane_cmd_t;

  // Status reported by one LED sequencer.
  typedef struct packed {
    logic pin;
    logic ready;
  } lane_status_t;

endpackage

// File: hw/rtl/mlfs_div.sv
// ----------------------------------------------------------------------------
// mlfs_div
// Two-stage divider of a millisecond time by the tick period. Stage one
// multiplies by the reciprocal, stage two corrects the estimate by one.
// ----------------------------------------------------------------------------
module mlfs_div
  import mlfs_pkg::*;
(
  input  logic              clk,
  input  logic [TIME_W-1:0] dividend,
  output logic [TIME_W-1:0] quotient
);

  logic [TIME_W-1:0]         x_r;
  logic [TIME_W-1:0]         est_r;
  logic [TIME_W-1:0]         quot_r;
  logic [TIME_W+RECIP_W-1:0] prod;
  logic [2*TIME_W-1:0]       back;
  logic [TIME_W-1:0]         rem;

  // The estimate is the true quotient or one below it.
  assign prod = (TIME_W+RECIP_W)'(dividend) * (TIME_W+RECIP_W)'(DIV_RECIP);

  always_ff @(posedge clk) begin
    x_r   <= dividend;
    est_r <= prod[DIV_SH +: TIME_W];
  end

  // Remainder of the estimate decides the correction.
  assign back = (2*TIME_W)'(est_r) * (2*TIME_W)'(TICK_VAL);
  assign rem  = x_r - back[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rem >= TICK_VAL) begin
      quot_r <= est_r + TIME_W'(1);
    end else begin
      quot_r <= est_r;
    end
  end

  assign quotient = quot_r;

endmodule

// File: hw/rtl/mlfs_lane.sv
// ----------------------------------------------------------------------------
// mlfs_lane
// Flash sequencer of one LED: idle, start, on and off phases with a tick
// countdown and a flash cycle counter. Pin is active low.
// ----------------------------------------------------------------------------
module mlfs_lane
  import mlfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lane_cmd_t    cmd,
  output lane_status_t status
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_START,
    PH_ON,
    PH_OFF
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  cycles_r, cycles_nxt;
  logic [TIME_W-1:0] on_r, on_nxt;
  logic [TIME_W-1:0] off_r, off_nxt;
  logic [TIME_W-1:0] ticks_r, ticks_nxt;
  logic              pin_r, pin_nxt;
  logic [TIME_W-1:0] ticks_dec;
  logic [CNT_W-1:0]  cycles_dec;

  assign ticks_dec  = ticks_r - TIME_W'(1);
  assign cycles_dec = cycles_r - CNT_W'(1);

  // Next state for a start request or one tick.
  always_comb begin
    phase_nxt  = phase_r;
    cycles_nxt = cycles_r;
    on_nxt     = on_r;
    off_nxt    = off_r;
    ticks_nxt  = ticks_r;
    pin_nxt    = pin_r;
    if (cmd.start) begin
      phase_nxt  = PH_START;
      cycles_nxt = cmd.cycles;
      on_nxt     = cmd.on_ticks;
      off_nxt    = cmd.off_ticks;
      ticks_nxt  = '0;
    end else if (cmd.tick) begin
      case (phase_r)
        PH_START: begin
          if (cycles_r == '0) begin
            pin_nxt   = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (off_r == '0) begin
            // No dark time: hold the LED lit.
            pin_nxt   = 1'b0;
            phase_nxt = PH_IDLE;
          end else begin
            ticks_nxt = on_r;
            phase_nxt = PH_ON;
            pin_nxt   = 1'b0;
          end
        end
        PH_ON: begin
          ticks_nxt = ticks_dec;
          if (ticks_dec == '0) begin
            ticks_nxt = off_r;
            phase_nxt = PH_OFF;
            pin_nxt   = 1'b1;
          end
        end
        PH_OFF: begin
          ticks_nxt = ticks_dec;
          if (ticks_dec == '0) begin
            if ((cycles_r != '0) && (cycles_dec == '0)) begin
              // Last flash done.
              cycles_nxt = cycles_dec;
              pin_nxt    = 1'b1;
              phase_nxt  = PH_IDLE;
            end else begin
              if (cycles_r != '0) begin
                cycles_nxt = cycles_dec;
              end
              ticks_nxt = on_r;
              phase_nxt = PH_ON;
              pin_nxt   = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cycles_r <= '0;
      on_r     <= '0;
      off_r    <= '0;
      ticks_r  <= '0;
      pin_r    <= 1'b1;
    end else begin
      phase_r  <= phase_nxt;
      cycles_r <= cycles_nxt;
      on_r     <= on_nxt;
      off_r    <= off_nxt;
      ticks_r  <= ticks_nxt;
      pin_r    <= pin_nxt;
    end
  end

  assign status.pin   = pin_r;
  assign status.ready = (phase_r == PH_IDLE) && (cycles_r == '0);

endmodule

// File: hw/rtl/mlfs_merge.sv
// ----------------------------------------------------------------------------
// mlfs_merge
// Combines the status of all LED sequencers into one result and holds it in
// the output register until the consumer takes it.
// ----------------------------------------------------------------------------
module mlfs_merge
  import mlfs_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lane_status_t lane_st [NUM_LEDS],
  input  logic         load,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output out_res_t     out_res
);

  logic [MASK_W-1:0]   pins;
  logic [MASK_W-1:0]   ready;
  logic [NUM_LEDS-1:0] lane_ready;
  out_res_t            res_r;
  logic                valid_r;

  // Visible bits come from the first LEDs; missing LEDs read dark, not ready.
  for (genvar i = 0; i < MASK_W; i++) begin : g_vis
    if (i < NUM_LEDS) begin : g_led
      assign pins[i]  = lane_st[i].pin;
      assign ready[i] = lane_st[i].ready;
    end else begin : g_none
      assign pins[i]  = 1'b1;
      assign ready[i] = 1'b0;
    end
  end

  // Every LED counts toward all-idle, including those not shown.
  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_rdy
    assign lane_ready[i] = lane_st[i].ready;
  end

  assign can_load = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.pin_levels <= pins;
      res_r.ready_mask <= ready;
      res_r.all_idle   <= &lane_ready;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: hw/rtl/multi_led_flash_sequencer.sv
// Flow: a start request passes the two-stage time divider (S_DIV1, S_DIV2), then the
// update and result steps S_APPLY and S_RESULT; a tick goes straight to S_APPLY.
// S_RESULT waits while the result register holds a result the consumer has not taken.
// One request at a time: in_ready is high only in S_IDLE, after the result is loaded.
// Reset (rst_n, synchronous): all LEDs idle and dark, counters cleared, no result pending.
// ----------------------------------------------------------------------------
// multi_led_flash_sequencer
// Top level: accepts start and tick requests, scales times to ticks, drives
// one sequencer per LED in parallel and merges their status into a result.
// ----------------------------------------------------------------------------
module multi_led_flash_sequencer
  import mlfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_res
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_APPLY,
    S_RESULT
  } state_t;

  state_t            state_r;
  in_req_t           req_r;
  logic [TIME_W-1:0] on_ticks;
  logic [TIME_W-1:0] off_ticks;
  logic              can_load;
  logic              res_load;
  lane_cmd_t         lane_cmd [NUM_LEDS];
  lane_status_t      lane_st [NUM_LEDS];

  assign in_ready = (state_r == S_IDLE);
  assign res_load = (state_r == S_RESULT) && can_load;

  // Control sequencer and request register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= (in_req.cmd == CMD_TICK) ? S_APPLY : S_DIV1;
          end
        end
        S_DIV1:   state_r <= S_DIV2;
        S_DIV2:   state_r <= S_APPLY;
        S_APPLY:  state_r <= S_RESULT;
        S_RESULT: begin
          if (can_load) begin
            state_r <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

  // Millisecond times to ticks, one divider per time.
  mlfs_div u_div_on (
    .clk      (clk),
    .dividend (req_r.on_time_ms),
    .quotient (on_ticks)
  );

  mlfs_div u_div_off (
    .clk      (clk),
    .dividend (req_r.off_time_ms),
    .quotient (off_ticks)
  );

  // One sequencer per LED; only the first mask bits can select a start.
  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_lane
    logic sel;
    if (i < MASK_W) begin : g_mask
      assign sel = req_r.led_mask[i];
    end else begin : g_nomask
      assign sel = 1'b0;
    end

    assign lane_cmd[i].start = (state_r == S_APPLY) && (req_r.cmd == CMD_START) && sel;
    assign lane_cmd[i].tick  = (state_r == S_APPLY) && (req_r.cmd == CMD_TICK);
    assign lane_cmd[i].on_ticks  = on_ticks;
    assign lane_cmd[i].off_ticks = off_ticks;
    assign lane_cmd[i].cycles    = req_r.flash_count;

    mlfs_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (lane_cmd[i]),
      .status (lane_st[i])
    );
  end

  mlfs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_st   (lane_st),
    .load      (res_load),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

endmodule

// File: hw/rtl/mlfs_checker.sv
// ----------------------------------------------------------------------------
// mlfs_checker
// Port-level checks of the flash sequencer, attached to the top level.
// ----------------------------------------------------------------------------
module mlfs_checker
  import mlfs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_res_t out_res
);

  // A pending result is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // Requests are handled one at a time.
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request accepted while one is in work");

  // All-idle means every visible LED reports ready.
  a_all_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.all_idle |-> out_res.ready_mask == READY_ALL)
    else $error("all-idle set while an LED is not ready");

  // A ready LED is always dark.
  a_ready_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res.ready_mask & ~out_res.pin_levels) == '0)
    else $error("ready LED shows a lit pin");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind multi_led_flash_sequencer mlfs_checker u_mlfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_res   (out_res)
);

// File: verif/multi_led_flash_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_led_flash_sequencer testbench
// Drives start and tick requests into the flash sequencer and compares every
// result with a cycle-free model of the per-LED phases held in this file.
// A short directed list covers reset, field extremes, zero counts, zero on
// and off times, masks and restarts. It is followed by random requests under
// several idle and stall patterns, a long consumer hold-off and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
  import mlfs_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_req;
  logic     out_valid;
  logic     out_ready;
  out_res_t out_res;

  multi_led_flash_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  // Phase of one LED sequencer, in the block's encoding.
  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_ARMED = 2'd1,
    SEQ_LIT   = 2'd2,
    SEQ_DARK  = 2'd3
  } seq_phase_t;

  // One row of the directed list; a typed result is used as is.
  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_res_t res;
  } directed_row_t;

  localparam int NUM_DIRECTED = 25;
  localparam int RANDOM_PER_PHASE = 250;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // Tick straight after reset: everything idle and dark.
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b1, '{4'hF, 4'hF, 1'b1}},
    // Largest settings on every LED: armed, still dark.
    '{'{CMD_START, 4'hF, 16'hFFFF,  16'hFFFF,  8'd255}, 1'b1, '{4'hF, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    // Restart with a zero count while lit: pins keep their level.
    '{'{CMD_START, 4'hF, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b1, '{4'hF, 4'hF, 1'b1}},
    // Zero off time with a nonzero count: held lit, never ready.
    '{'{CMD_START, 4'h1, 16'd35,    16'd0,     8'd5},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_START, 4'h1, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b1, '{4'hF, 4'hF, 1'b1}},
    // Two full flashes on LED 1: two ticks lit, one dark.
    '{'{CMD_START, 4'h2, 16'd20,    16'd10,    8'd2},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    // On time below one tick: the lit counter wraps.
    '{'{CMD_START, 4'h4, 16'd9,     16'd15,    8'd1},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'h0, 16'd0,     16'd0,     8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    // Restart mid-flight, then an empty mask that changes nothing.
    '{'{CMD_START, 4'h4, 16'hFFFF,  16'hFFFF,  8'd0},   1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_START, 4'h0, 16'hFFFF,  16'hFFFF,  8'd255}, 1'b0, '{4'h0, 4'h0, 1'b0}},
    '{'{CMD_TICK,  4'hF, 16'hFFFF,  16'hFFFF,  8'd255}, 1'b1, '{4'hF, 4'hF, 1'b1}},
    '{'{CMD_START, 4'h8, 16'd19,    16'd29,    8'd1},   1'b0, '{4'h0, 4'h0, 1'b0}}
  };

  // Model state, one entry per LED.
  seq_phase_t        led_phase  [NUM_LEDS];
  logic [CNT_W-1:0]  led_cycles [NUM_LEDS];
  logic [TIME_W-1:0] led_on     [NUM_LEDS];
  logic [TIME_W-1:0] led_off    [NUM_LEDS];
  logic [TIME_W-1:0] led_left   [NUM_LEDS];
  logic              led_pin    [NUM_LEDS];

  out_res_t flash_expected [$];
  int       mismatch_count = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  int       hold_off_cycles = 0;

  // Advance one LED by one tick.
  function automatic void advance_led(int i);
    logic finished;
    finished = 1'b0;
    case (led_phase[i])
      SEQ_ARMED: begin
        if (led_cycles[i] == '0) begin
          led_pin[i]   = 1'b1;
          led_phase[i] = SEQ_IDLE;
        end else if (led_off[i] == '0) begin
          led_pin[i]   = 1'b0;
          led_phase[i] = SEQ_IDLE;
        end else begin
          led_left[i]  = led_on[i];
          led_phase[i] = SEQ_LIT;
          led_pin[i]   = 1'b0;
        end
      end
      SEQ_LIT: begin
        led_left[i] = led_left[i] - 1'b1;
        if (led_left[i] == '0) begin
          led_left[i]  = led_off[i];
          led_phase[i] = SEQ_DARK;
          led_pin[i]   = 1'b1;
        end
      end
      SEQ_DARK: begin
        led_left[i] = led_left[i] - 1'b1;
        if (led_left[i] == '0) begin
          if (led_cycles[i] != '0) begin
            led_cycles[i] = led_cycles[i] - 1'b1;
            finished = (led_cycles[i] == '0);
          end
          if (finished) begin
            led_pin[i]   = 1'b1;
            led_phase[i] = SEQ_IDLE;
          end else begin
            led_left[i]  = led_on[i];
            led_phase[i] = SEQ_LIT;
            led_pin[i]   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Apply one request to the model and return the result it produces.
  function automatic out_res_t flash_predict(in_req_t req);
    out_res_t res;
    logic     rdy;
    if (req.cmd == CMD_START) begin
      for (int i = 0; i < NUM_LEDS && i < MASK_W; i++) begin
        if (req.led_mask[i]) begin
          led_phase[i]  = SEQ_ARMED;
          led_cycles[i] = req.flash_count;
          led_on[i]     = TIME_W'(req.on_time_ms / TICK_MS);
          led_off[i]    = TIME_W'(req.off_time_ms / TICK_MS);
          led_left[i]   = '0;
        end
      end
    end else begin
      for (int i = 0; i < NUM_LEDS; i++) advance_led(i);
    end
    res.pin_levels = '1;
    res.ready_mask = '0;
    res.all_idle   = 1'b1;
    for (int i = 0; i < NUM_LEDS; i++) begin
      rdy = (led_phase[i] == SEQ_IDLE) && (led_cycles[i] == '0);
      if (!rdy) res.all_idle = 1'b0;
      if (i < MASK_W) begin
        if (!led_pin[i]) res.pin_levels[i] = 1'b0;
        if (rdy) res.ready_mask[i] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Offer one request, wait for it to be taken and record its result.
  task automatic issue_request(input in_req_t req, input logic use_typed,
                               input out_res_t typed_res);
    out_res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    predicted = flash_predict(req);
    flash_expected.push_back(use_typed ? typed_res : predicted);
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result consumer: random stalls, plus a long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles - 1) @(negedge clk);
        hold_off_cycles = 0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : result_check
    out_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (flash_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_res));
      end else begin
        want = flash_expected.pop_front();
        if (out_res.pin_levels !== want.pin_levels)
          report_mismatch($sformatf("pin_levels %h, expected %h",
                                    out_res.pin_levels, want.pin_levels));
        if (out_res.ready_mask !== want.ready_mask)
          report_mismatch($sformatf("ready_mask %h, expected %h",
                                    out_res.ready_mask, want.ready_mask));
        if (out_res.all_idle !== want.all_idle)
          report_mismatch($sformatf("all_idle %b, expected %b",
                                    out_res.all_idle, want.all_idle));
      end
    end
  end

  // Stimulus: reset, directed list, then random phases.
  initial begin : stimulus
    in_req_t req;
    int      pick;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_req   = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      led_phase[i]  = SEQ_IDLE;
      led_cycles[i] = '0;
      led_on[i]     = '0;
      led_off[i]    = '0;
      led_left[i]   = '0;
      led_pin[i]    = 1'b1;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      issue_request(DIRECTED_ROWS[n].req, DIRECTED_ROWS[n].typed, DIRECTED_ROWS[n].res);
    end

    // Phases: no idling, sender idle, consumer stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct    = (ph == 1) ? 63 : (ph == 3) ? 38 : 0;
      receiver_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 38 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Back-pressure the block while requests keep coming.
        if (ph == 0 && n == 100) hold_off_cycles = HOLD_OFF_CYCLES;
        req.cmd         = ($urandom_range(99) < 75) ? CMD_TICK : CMD_START;
        req.led_mask    = MASK_W'($urandom);
        req.on_time_ms  = TIME_W'($urandom);
        req.off_time_ms = TIME_W'($urandom);
        req.flash_count = CNT_W'($urandom);
        pick = $urandom_range(9);
        // Most starts use short times and counts so LEDs cycle through phases.
        if (req.cmd == CMD_START && pick != 0) begin
          req.on_time_ms  = TIME_W'($urandom_range((pick == 1) ? 0 : 10, 59));
          req.off_time_ms = TIME_W'($urandom_range(0, 59));
          req.flash_count = CNT_W'($urandom_range(0, 4));
        end
        issue_request(req, 1'b0, '0);
      end
      // Let the pipeline drain completely before the next phase.
      @(negedge clk);
      in_valid <= 1'b0;
      while (flash_expected.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && flash_expected.size() == 0) begin
      $display("multi_led_flash_sequencer regression: pass");
    end else begin
      $display("multi_led_flash_sequencer regression: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("multi_led_flash_sequencer regression: fail");
    $finish;
  end

endmodule
